// ----- rtl/utc_cal_pkg.sv -----
// shared constants, types and tables for the unix time to calendar converter
package utc_cal_pkg;

    // pipeline shape
    localparam int NSTG     = 11;          // register stages, input to output
    localparam int DATE_STG = NSTG - 2;    // stages of the civil date datapath
    localparam int TOD_LEN  = NSTG - 3;    // time of day carried from stage 4 on

    // calendar constants
    localparam int SEC_DAY    = 86400;
    localparam int SEC_MIN    = 60;
    localparam int MIN_HOUR   = 60;
    localparam int HOUR_DAY   = 24;
    localparam int SEC_HOUR   = SEC_MIN * MIN_HOUR;
    localparam int SHIFT_DAYS = 719468;    // 1970-01-01 counted from 0000-03-01
    localparam int ERA_DAYS   = 146097;
    localparam int CENT_DAYS  = 36524;
    localparam int QUAD_DAYS  = 3 * 365 + 366;
    localparam int YEAR_DAYS  = 365;
    localparam int ERA_YEARS  = 400;
    localparam int LEAP_SPAN  = 4;
    localparam int CENT_YEARS = 100;
    localparam int WEEK_DAYS  = 7;
    localparam int SHIFT_WDAY = 3;         // 0000-03-01 was a wednesday
    localparam int WDAY_OFS   = (SHIFT_DAYS + SHIFT_WDAY) % WEEK_DAYS;
    localparam int MONTHS     = 12;
    localparam int MP_MUL     = 5;
    localparam int MP_ADD     = 2;
    localparam int MP_DIV     = 153;
    localparam int MP_JAN     = 10;        // march-based index of january
    localparam int MAR_MONTH  = 2;         // march in the january-based count
    localparam int YEAR_LO    = 1970;
    localparam int YEAR_HI    = 2106;

    // seconds to days: drop the power-of-two factor, then divide by the odd part
    localparam int DAY_PRE = 7;
    localparam int DAY_ODD = SEC_DAY >> DAY_PRE;

    // reciprocal multipliers, rounded up, shift chosen so the quotient is exact
    // over the whole operand range
    localparam int DAY_K  = 35;
    localparam int WEEK_K = 19;
    localparam int HOUR_K = 29;
    localparam int MIN_K  = 23;
    localparam int ERA_K  = 38;
    localparam int QUAD_K = 29;
    localparam int CENT_K = 34;
    localparam int YEAR_K = 27;
    localparam int C100_K = 16;
    localparam int MP_K   = 19;

    localparam logic [25:0] DAY_M  = 26'(((64'd1 << DAY_K) + 64'(DAY_ODD) - 64'd1)
                                         / 64'(DAY_ODD));
    localparam logic [16:0] WEEK_M = 17'(((64'd1 << WEEK_K) + 64'(WEEK_DAYS) - 64'd1)
                                         / 64'(WEEK_DAYS));
    localparam logic [17:0] HOUR_M = 18'(((64'd1 << HOUR_K) + 64'(SEC_HOUR) - 64'd1)
                                         / 64'(SEC_HOUR));
    localparam logic [17:0] MIN_M  = 18'(((64'd1 << MIN_K) + 64'(SEC_MIN) - 64'd1)
                                         / 64'(SEC_MIN));
    localparam logic [20:0] ERA_M  = 21'(((64'd1 << ERA_K) + 64'(ERA_DAYS) - 64'd1)
                                         / 64'(ERA_DAYS));
    localparam logic [18:0] QUAD_M = 19'(((64'd1 << QUAD_K) + 64'(QUAD_DAYS - 1) - 64'd1)
                                         / 64'(QUAD_DAYS - 1));
    localparam logic [18:0] CENT_M = 19'(((64'd1 << CENT_K) + 64'(CENT_DAYS) - 64'd1)
                                         / 64'(CENT_DAYS));
    localparam logic [18:0] YEAR_M = 19'(((64'd1 << YEAR_K) + 64'(YEAR_DAYS) - 64'd1)
                                         / 64'(YEAR_DAYS));
    localparam logic [9:0]  C100_M = 10'(((64'd1 << C100_K) + 64'(CENT_YEARS) - 64'd1)
                                         / 64'(CENT_YEARS));
    localparam logic [11:0] MP_M   = 12'(((64'd1 << MP_K) + 64'(MP_DIV) - 64'd1)
                                         / 64'(MP_DIV));

    // time of day fields carried alongside the date stages
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
    } t_tod;

    // first day of each march-based month within the march-based year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/utc_cal_date.sv -----
// civil date datapath: shifted day count to year, month and day of month
module utc_cal_date
    import utc_cal_pkg::*;
(
    input  logic                i_clk,
    input  logic [DATE_STG-1:0] i_adv,
    input  logic [19:0]         i_days,
    output logic [11:0]         o_year,
    output logic [3:0]          o_month,
    output logic [4:0]          o_day
);

    logic [40:0] n_era_prod;
    logic [36:0] n_quad_prod;
    logic [36:0] n_cent_prod;
    logic [36:0] n_year_prod;
    logic [18:0] n_c100_prod;
    logic [23:0] n_mp_prod;
    logic        n_jan_feb;

    logic [19:0] r_days;
    logic [2:0]  r_era [DATE_STG-1];
    logic [17:0] r_eday4;
    logic [17:0] r_eday5;
    logic [6:0]  r_quad;
    logic [2:0]  r_cent;
    logic        r_last;
    logic [17:0] r_eday6;
    logic [17:0] r_n;
    logic [17:0] r_eday7;
    logic [8:0]  r_ey7;
    logic [17:0] r_eday8;
    logic [8:0]  r_ey8;
    logic [17:0] r_yb;
    logic [1:0]  r_c100;
    logic [8:0]  r_ey9;
    logic [8:0]  r_yday9;
    logic [8:0]  r_ey10;
    logic [8:0]  r_yday10;
    logic [3:0]  r_mp;
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;

    // reciprocal products
    assign n_era_prod  = 41'(i_days) * 41'(ERA_M);
    assign n_quad_prod = 37'(r_eday4) * 37'(QUAD_M);
    assign n_cent_prod = 37'(r_eday4) * 37'(CENT_M);
    assign n_year_prod = 37'(r_n) * 37'(YEAR_M);
    assign n_c100_prod = 19'(r_ey7) * 19'(C100_M);
    assign n_mp_prod   = 24'(r_yday9) * 24'(MP_MUL * int'(MP_M))
                       + 24'(MP_ADD * int'(MP_M));
    assign n_jan_feb   = (r_mp >= 4'(MP_JAN));

    // era split, then day of era
    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_days   <= i_days;
            r_era[0] <= n_era_prod[ERA_K +: 3];
        end
        for (int s = 1; s < DATE_STG - 1; s++) begin
            if (i_adv[s]) begin
                r_era[s] <= r_era[s-1];
            end
        end
        if (i_adv[1]) begin
            r_eday4 <= 18'(r_days - 20'(r_era[0]) * 20'(ERA_DAYS));
        end
    end

    // four-year, century and era corrections, then year of era
    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            r_eday5 <= r_eday4;
            r_quad  <= n_quad_prod[QUAD_K +: 7];
            r_cent  <= n_cent_prod[CENT_K +: 3];
            r_last  <= (r_eday4 >= 18'(ERA_DAYS - 1));
        end
        if (i_adv[3]) begin
            r_eday6 <= r_eday5;
            r_n     <= r_eday5 - 18'(r_quad) + 18'(r_cent) - 18'(r_last);
        end
        if (i_adv[4]) begin
            r_eday7 <= r_eday6;
            r_ey7   <= n_year_prod[YEAR_K +: 9];
        end
    end

    // day of the march-based year
    always_ff @(posedge i_clk) begin
        if (i_adv[5]) begin
            r_eday8 <= r_eday7;
            r_ey8   <= r_ey7;
            r_yb    <= 18'(r_ey7) * 18'(YEAR_DAYS);
            r_c100  <= n_c100_prod[C100_K +: 2];
        end
        if (i_adv[6]) begin
            r_ey9   <= r_ey8;
            r_yday9 <= 9'(r_eday8 - r_yb - 18'(r_ey8 / LEAP_SPAN) + 18'(r_c100));
        end
    end

    // month from day of year, then final fields
    always_ff @(posedge i_clk) begin
        if (i_adv[7]) begin
            r_ey10   <= r_ey9;
            r_yday10 <= r_yday9;
            r_mp     <= n_mp_prod[MP_K +: 4];
        end
        if (i_adv[8]) begin
            r_day   <= 5'(r_yday10 - month_start(r_mp) + 9'd1);
            r_month <= n_jan_feb ? (r_mp - 4'(MP_JAN)) : (r_mp + 4'(MAR_MONTH));
            r_year  <= 12'(r_ey10) + 12'(r_era[DATE_STG-2]) * 12'(ERA_YEARS)
                     + 12'(n_jan_feb);
        end
    end

    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_day;

endmodule

// ----- rtl/unix_time_to_calendar.sv -----
// unix_time_to_calendar: 32-bit unix seconds to utc calendar fields, pipelined
//
// Converts an unsigned 32-bit unix timestamp into the utc year, month (0 is
// january), day of month, hour, minute, second and weekday (0 is sunday).
// The converter is an 11-stage pipeline that takes one timestamp per cycle
// while its input is not stalled. Every division is by a constant, done as a
// shift or a reciprocal multiply, one multiplier deep per stage. A stall on
// the output holds the last stage; the stages behind it keep filling their
// empty slots, so input stall rises only when all 11 stages hold items.
module unix_time_to_calendar
    import utc_cal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_timestamp,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic [2:0]  o_weekday
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_adv;
    logic [50:0]     n_day_prod;
    logic [15:0]     n_wx;
    logic [32:0]     n_week_prod;
    logic [34:0]     n_hour_prod;
    logic [34:0]     n_min_prod;
    t_tod            n_tod;

    logic [31:0] r_ts;
    logic [15:0] r_q;
    logic [16:0] r_rem2;
    logic [19:0] r_days;
    logic [15:0] r_wx;
    logic [12:0] r_wq;
    logic [16:0] r_rem3;
    logic [4:0]  r_hour3;
    logic [10:0] r_mt;
    logic [2:0]  r_wday3;
    t_tod        r_tod [TOD_LEN];

    // per-stage advance: a stage loads when it is empty or its successor moves
    always_comb begin
        n_adv[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int s = NSTG - 2; s >= 0; s--) begin
            n_adv[s] = !r_vld[s] || n_adv[s+1];
        end
    end

    assign o_stall = !n_adv[0];
    assign o_valid = r_vld[NSTG-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (n_adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // reciprocal products for day count, weekday and time of day
    assign n_day_prod  = 51'(i_timestamp[31:DAY_PRE]) * 51'(DAY_M);
    assign n_wx        = r_q + 16'(WDAY_OFS);
    assign n_week_prod = 33'(n_wx) * 33'(WEEK_M);
    assign n_hour_prod = 35'(r_rem2) * 35'(HOUR_M);
    assign n_min_prod  = 35'(r_rem2) * 35'(MIN_M);

    // whole days; seconds of day, shifted days, week quotient; hour, total minutes, weekday
    always_ff @(posedge i_clk) begin
        if (n_adv[0]) begin
            r_ts <= i_timestamp;
            r_q  <= n_day_prod[DAY_K +: 16];
        end
        if (n_adv[1]) begin
            r_rem2 <= 17'(r_ts - 32'(r_q) * 32'(SEC_DAY));
            r_days <= 20'(r_q) + 20'(SHIFT_DAYS);
            r_wx   <= n_wx;
            r_wq   <= n_week_prod[WEEK_K +: 13];
        end
        if (n_adv[2]) begin
            r_rem3  <= r_rem2;
            r_hour3 <= n_hour_prod[HOUR_K +: 5];
            r_mt    <= n_min_prod[MIN_K +: 11];
            r_wday3 <= 3'(r_wx - 16'(r_wq) * 16'(WEEK_DAYS));
        end
    end

    // minute and second from the remainders
    always_comb begin
        n_tod.hour    = r_hour3;
        n_tod.minute  = 6'(r_mt - 11'(r_hour3) * 11'(MIN_HOUR));
        n_tod.second  = 6'(r_rem3 - 17'(r_mt) * 17'(SEC_MIN));
        n_tod.weekday = r_wday3;
    end

    // time of day rides along with the date stages
    always_ff @(posedge i_clk) begin
        if (n_adv[3]) begin
            r_tod[0] <= n_tod;
        end
        for (int j = 1; j < TOD_LEN; j++) begin
            if (n_adv[j+3]) begin
                r_tod[j] <= r_tod[j-1];
            end
        end
    end

    // civil date from the shifted day count
    utc_cal_date u_date (
        .i_clk   (i_clk),
        .i_adv   (n_adv[NSTG-1:2]),
        .i_days  (r_days),
        .o_year  (o_year),
        .o_month (o_month),
        .o_day   (o_day)
    );

    assign o_hour    = r_tod[TOD_LEN-1].hour;
    assign o_minute  = r_tod[TOD_LEN-1].minute;
    assign o_second  = r_tod[TOD_LEN-1].second;
    assign o_weekday = r_tod[TOD_LEN-1].weekday;

    // input stall only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_vld) && i_stall))
        else $error("input stalled while a stage is free");

    // time fields stay in range on every delivered result
    a_tod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour < 5'(HOUR_DAY) && o_minute < 6'(MIN_HOUR)
                     && o_second < 6'(SEC_MIN) && o_weekday < 3'(WEEK_DAYS)))
        else $error("time of day field out of range");

    // date fields stay in range on every delivered result
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month < 4'(MONTHS) && o_day != 5'd0
                     && o_year >= 12'(YEAR_LO) && o_year <= 12'(YEAR_HI)))
        else $error("date field out of range");

endmodule

// ----- dv/tb.sv -----
// testbench for unix_time_to_calendar: random and directed timestamps checked against a predictor
module tb;
    import utc_cal_pkg::*;

    localparam int ITEMS_PER_PHASE = 570;
    localparam int HOLD_CYCLES     = 80;
    localparam int IDLE_LIMIT      = 3000;
    localparam int MAX_PRINTED     = 50;

    // one broken-down date as the block reports it
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
    } t_cal;

    // expected dates in transfer order, with the timestamp that caused each
    class calendar_board;
        t_cal        expected_dates[$];
        logic [31:0] source_stamps[$];
        int          errors;

        // civil-from-days conversion with the march-based year
        function t_cal to_calendar(logic [31:0] ts);
            t_cal        r;
            int unsigned days, rem, era, eday, eyear, yday, mp, dom, mon, yr;
            days  = ts / 86400 + 719468;
            rem   = ts % 86400;
            era   = days / 146097;
            eday  = days - era * 146097;
            eyear = (eday - eday / 1460 + eday / 36524 - eday / 146096) / 365;
            yday  = eday - (365 * eyear + eyear / 4 - eyear / 100);
            mp    = (5 * yday + 2) / 153;
            dom   = yday - (153 * mp + 2) / 5 + 1;
            mon   = (mp < 10) ? mp + 2 : mp - 10;
            yr    = eyear + era * 400 + ((mon <= 1) ? 1 : 0);
            r.year    = yr[11:0];
            r.month   = mon[3:0];
            r.day     = dom[4:0];
            r.hour    = 5'(rem / 3600);
            r.minute  = 6'((rem % 3600) / 60);
            r.second  = 6'(rem % 60);
            r.weekday = 3'((days + 3) % 7);
            return r;
        endfunction

        function void note_input(logic [31:0] ts);
            expected_dates.push_back(to_calendar(ts));
            source_stamps.push_back(ts);
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("mismatch: %s", msg);
            end
        endtask

        task check_field(string name, int unsigned got, int unsigned exp, logic [31:0] ts);
            if (got != exp) begin
                report($sformatf("ts %0d %s got %0d exp %0d", ts, name, got, exp));
            end
        endtask

        task check_result(t_cal got);
            t_cal        exp;
            logic [31:0] ts;
            if (expected_dates.size() == 0) begin
                report("result transfer with nothing outstanding");
            end else begin
                exp = expected_dates.pop_front();
                ts  = source_stamps.pop_front();
                check_field("year", 32'(got.year), 32'(exp.year), ts);
                check_field("month", 32'(got.month), 32'(exp.month), ts);
                check_field("day", 32'(got.day), 32'(exp.day), ts);
                check_field("hour", 32'(got.hour), 32'(exp.hour), ts);
                check_field("minute", 32'(got.minute), 32'(exp.minute), ts);
                check_field("second", 32'(got.second), 32'(exp.second), ts);
                check_field("weekday", 32'(got.weekday), 32'(exp.weekday), ts);
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_timestamp;
    logic        o_valid;
    logic        i_stall;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;
    logic [2:0]  o_weekday;

    calendar_board board = new;
    int            send_idle_pct;
    int            recv_idle_pct;
    bit            hold_go;

    unix_time_to_calendar i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_timestamp(i_timestamp),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_year     (o_year),
        .o_month    (o_month),
        .o_day      (o_day),
        .o_hour     (o_hour),
        .o_minute   (o_minute),
        .o_second   (o_second),
        .o_weekday  (o_weekday)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // output side stall, with one long hold-off on request
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_result({o_year, o_month, o_day, o_hour, o_minute, o_second,
                                o_weekday});
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL unix_time_to_calendar");
        $finish;
    end

    // offer one timestamp, with random idle cycles in front of it
    task send_stamp(logic [31:0] ts);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_timestamp <= ts;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        board.note_input(ts);
    endtask

    // random timestamp: full range, day boundaries, or sparse or dense bit patterns
    function automatic logic [31:0] random_stamp();
        logic [63:0] t;
        int unsigned pick;
        pick = $urandom_range(3);
        if (pick == 0 || pick == 1) begin
            t = 64'($urandom);
        end else if (pick == 2) begin
            t = 64'($urandom_range(49710)) * 64'd86400;
            if ($urandom_range(1) == 1) begin
                t = t + 64'($urandom_range(3));
            end else begin
                t = t + 64'd86396 + 64'($urandom_range(3));
            end
            if (t > 64'hFFFF_FFFF) begin
                t = 64'($urandom);
            end
        end else begin
            t = 64'($urandom & $urandom);
            if ($urandom_range(1) == 1) begin
                t = t ^ 64'hFFFF_FFFF;
            end
        end
        return t[31:0];
    endfunction

    task run_phase(int s_pct, int r_pct, bit with_hold);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (with_hold) begin
            hold_go = 1'b1;
        end
        repeat (ITEMS_PER_PHASE) send_stamp(random_stamp());
    endtask

    // main sequence
    initial begin
        logic [31:0] directed[$];
        int          settle;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_timestamp   = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // epoch, range ends, day and year edges, leap days in 1972 and 2000, non-leap 2100
        directed = '{32'd0, 32'd1, 32'd59, 32'd3599, 32'd86399, 32'd86400,
                     32'd31535999, 32'd31536000, 32'd68169600, 32'd68255999,
                     32'd946684799, 32'd946684800, 32'd951782400, 32'd951868800,
                     32'd2147483647, 32'd2147483648, 32'd4102444799, 32'd4107542399,
                     32'd4107542400, 32'hAAAA_AAAA, 32'h5555_5555, 32'd4294944000,
                     32'hFFFF_FFFE, 32'hFFFF_FFFF};
        foreach (directed[i]) send_stamp(directed[i]);

        run_phase(20, 62, 1'b0);
        run_phase(62, 20, 1'b0);
        run_phase(0, 0, 1'b1);
        @(negedge i_clk);
        i_valid <= 1'b0;

        // drain, then keep watching for stray results
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        settle = NSTG + 5;
        repeat (settle) @(posedge i_clk);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASS unix_time_to_calendar");
        end else begin
            $display("FAIL unix_time_to_calendar");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/utc_cal_pkg.sv
rtl/utc_cal_date.sv
rtl/unix_time_to_calendar.sv
dv/tb.sv
